// ===== src/cdf_pkg.sv =====
package cdf_pkg;

	// Widths fixed by the frame format.
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 6;
	localparam int CNT_W  = 4;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// CRC-8 generator polynomial, MSB first, and the bits per byte.
	localparam byte_t CRC_POLY      = 8'h07;
	localparam cnt_t  BITS_PER_BYTE = 4'd8;

	// Start-of-frame byte after reset.
	localparam byte_t HEADER_RESET = 8'hAA;

	// Position within a frame.
	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_CMD  = 3'd1,
		PH_LEN  = 3'd2,
		PH_DATA = 3'd3,
		PH_CRC  = 3'd4
	} phase_t;

	// Sequencer states of the block.
	typedef enum logic [1:0] {
		CTL_IDLE  = 2'd0,
		CTL_SHIFT = 2'd1,
		CTL_READ  = 2'd2,
		CTL_SEND  = 2'd3
	} ctl_t;

	// Command to the bit-serial CRC unit.
	typedef struct packed {
		logic  start;
		logic  clear;
		byte_t data;
	} crc_ctl_t;

endpackage

// ===== src/cdf_rx_if.sv =====
interface cdf_rx_if;
	logic            valid;
	logic            ready;
	cdf_pkg::byte_t  byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink   (input valid, input byte_in, output ready);
endinterface

// ===== src/cdf_tx_if.sv =====
interface cdf_tx_if;
	logic            valid;
	logic            ready;
	cdf_pkg::byte_t  command;
	cdf_pkg::len_t   payload_length;
	logic            has_byte;
	cdf_pkg::byte_t  data_byte;
	logic            last;

	modport source (output valid, output command, output payload_length, output has_byte,
		output data_byte, output last, input ready);
	modport sink   (input valid, input command, input payload_length, input has_byte,
		input data_byte, input last, output ready);
endinterface

// ===== src/cdf_cfg_if.sv =====
interface cdf_cfg_if;
	logic            valid;
	logic            ready;
	cdf_pkg::byte_t  header_byte;

	modport source (output valid, output header_byte, input ready);
	modport sink   (input valid, input header_byte, output ready);
endinterface

// ===== src/cdf_crc.sv =====
module cdf_crc (
	input  logic               clk,
	input  logic               arst_n,
	input  cdf_pkg::crc_ctl_t  ctl,
	output cdf_pkg::byte_t     crc,
	output logic               busy
);
	import cdf_pkg::*;

	byte_t crc_q;
	cnt_t  cnt_q;

	// Load the xor of the running value (zero when clear is set) and the new byte, then shift one bit a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			crc_q <= (ctl.clear ? byte_t'(0) : crc_q) ^ ctl.data;
			cnt_q <= BITS_PER_BYTE;
		end else if (cnt_q != '0) begin
			if (crc_q[BYTE_W-1]) begin
				crc_q <= {crc_q[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				crc_q <= {crc_q[BYTE_W-2:0], 1'b0};
			end
			cnt_q <= cnt_q - cnt_t'(1);
		end
	end

	assign crc  = crc_q;
	assign busy = (cnt_q != '0);

endmodule

// ===== src/cdf_store.sv =====
module cdf_store #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  cdf_pkg::byte_t      wr_data,
	input  logic [AW-1:0]       rd_addr,
	output cdf_pkg::byte_t      rd_data
);
	import cdf_pkg::*;

	byte_t mem [DEPTH];
	byte_t rd_data_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/crc8_packet_deframer_core.sv =====
// Length-prefixed frame parser with a CRC-8 check (polynomial 0x07, init 0).
// rx carries one received byte per transaction; cfg writes the start-of-frame
// byte (always ready), which the user must do only while the block is idle;
// the block does not enforce that. tx delivers one result per payload byte of
// a good packet, or a single empty result with last set for a zero-length
// packet. A byte taken while hunting, a rejected length byte or a mismatched
// CRC byte leaves rx ready again on the next cycle. A command, length or payload
// byte is folded into the CRC one bit a cycle by a serial unit, and rx stays
// not ready until that unit is idle. When the CRC byte matches, results follow
// from the payload memory, each via a read and a send state, as the memory's
// read port is registered. A stall on tx simply holds the current result, and
// rx stays not ready until the last result of the packet has been taken.
// Reset returns the block to hunting for the header byte, sets the header
// byte to 0xAA and leaves tx empty; the payload memory is not cleared.
module crc8_packet_deframer_core #(
	parameter int MAX_LEN = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	cdf_rx_if.sink    rx,
	cdf_tx_if.source  tx,
	cdf_cfg_if.sink   cfg
);
	import cdf_pkg::*;

	localparam int    AW          = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam byte_t MaxLenByte  = byte_t'(MAX_LEN);
	localparam len_t  MaxLenCount = len_t'(MAX_LEN);

	ctl_t     ctl_q, ctl_d;
	phase_t   phase_q, phase_d;
	byte_t    header_q;
	byte_t    command_q;
	len_t     length_q;
	len_t     windex_q;
	len_t     rd_ptr_q;
	logic     has_byte_q;
	logic     last_q;

	crc_ctl_t crc_ctl;
	byte_t    crc_val;
	logic     crc_busy;
	logic     store_wr;
	byte_t    rd_data;

	logic     rx_fire;
	logic     tx_fire;
	logic     len_ok;
	logic     crc_match;
	len_t     windex_next;

	assign rx_fire     = rx.valid && rx.ready;
	assign tx_fire     = tx.valid && tx.ready;
	assign len_ok      = (rx.byte_in <= MaxLenByte);
	assign crc_match   = (rx.byte_in == crc_val);
	assign windex_next = windex_q + len_t'(1);

	// Start-of-frame register.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg.valid) begin
			header_q <= cfg.header_byte;
		end
	end

	// Frame phase after the byte being taken.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_CMD: phase_d = PH_LEN;
			PH_LEN: begin
				if (!len_ok) begin
					phase_d = PH_HUNT;
				end else if (rx.byte_in[LEN_W-1:0] == '0) begin
					phase_d = PH_CRC;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (windex_next >= length_q) begin
					phase_d = PH_CRC;
				end
			end
			PH_CRC:  phase_d = PH_HUNT;
			default: phase_d = (rx.byte_in == header_q) ? PH_CMD : PH_HUNT;
		endcase
	end

	// Sequencer next state.
	always_comb begin
		ctl_d = ctl_q;
		case (ctl_q)
			CTL_IDLE: begin
				if (rx_fire) begin
					case (phase_q)
						PH_CMD, PH_DATA: ctl_d = CTL_SHIFT;
						PH_LEN: ctl_d = len_ok ? CTL_SHIFT : CTL_IDLE;
						PH_CRC: begin
							if (crc_match) begin
								ctl_d = (length_q == '0) ? CTL_SEND : CTL_READ;
							end
						end
						default: ctl_d = CTL_IDLE;
					endcase
				end
			end
			CTL_SHIFT: begin
				if (!crc_busy) begin
					ctl_d = CTL_IDLE;
				end
			end
			CTL_READ: ctl_d = CTL_SEND;
			CTL_SEND: begin
				if (tx_fire) begin
					ctl_d = last_q ? CTL_IDLE : CTL_READ;
				end
			end
			default: ctl_d = CTL_IDLE;
		endcase
	end

	// Sequencer outputs: handshakes, CRC command and memory write.
	always_comb begin
		rx.ready      = 1'b0;
		tx.valid      = 1'b0;
		crc_ctl.start = 1'b0;
		crc_ctl.clear = 1'b0;
		crc_ctl.data  = rx.byte_in;
		store_wr      = 1'b0;
		case (ctl_q)
			CTL_IDLE: begin
				rx.ready = 1'b1;
				if (rx.valid) begin
					case (phase_q)
						PH_CMD: begin
							crc_ctl.start = 1'b1;
							crc_ctl.clear = 1'b1;
						end
						PH_LEN:  crc_ctl.start = len_ok;
						PH_DATA: begin
							crc_ctl.start = 1'b1;
							store_wr      = (windex_q < MaxLenCount);
						end
						default: crc_ctl.start = 1'b0;
					endcase
				end
			end
			CTL_SEND: tx.valid = 1'b1;
			default: begin
				rx.ready = 1'b0;
			end
		endcase
	end

	// State, frame registers and result flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q      <= CTL_IDLE;
			phase_q    <= PH_HUNT;
			command_q  <= '0;
			length_q   <= '0;
			windex_q   <= '0;
			rd_ptr_q   <= '0;
			has_byte_q <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			ctl_q <= ctl_d;
			if (rx_fire) begin
				phase_q <= phase_d;
				case (phase_q)
					PH_CMD: command_q <= rx.byte_in;
					PH_LEN: begin
						if (len_ok) begin
							length_q <= rx.byte_in[LEN_W-1:0];
							windex_q <= '0;
						end
					end
					PH_DATA: windex_q <= windex_next;
					PH_CRC: begin
						rd_ptr_q   <= '0;
						has_byte_q <= (length_q != '0);
						last_q     <= (length_q == '0);
					end
					default: windex_q <= windex_q;
				endcase
			end
			if (ctl_q == CTL_READ) begin
				last_q <= ((rd_ptr_q + len_t'(1)) == length_q);
			end
			if (tx_fire && !last_q) begin
				rd_ptr_q <= rd_ptr_q + len_t'(1);
			end
		end
	end

	cdf_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.crc    (crc_val),
		.busy   (crc_busy)
	);

	cdf_store #(
		.DEPTH (MAX_LEN),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (store_wr),
		.wr_addr (windex_q[AW-1:0]),
		.wr_data (rx.byte_in),
		.rd_addr (rd_ptr_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Result payload; the memory read register holds the byte during a stall.
	assign tx.command        = command_q;
	assign tx.payload_length = length_q;
	assign tx.has_byte       = has_byte_q;
	assign tx.data_byte      = has_byte_q ? rd_data : byte_t'(0);
	assign tx.last           = last_q;

endmodule

// ===== bench/tb_crc8_packet_deframer_core.sv =====
module tb_crc8_packet_deframer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import cdf_pkg::*;

	localparam int MAX_PAY     = 32;
	localparam int PER_PHASE   = 44;
	localparam int N_PHASES    = 5;
	localparam int SETTLE      = 40;
	localparam int DRAIN_LIMIT = 20000;
	localparam int HOLD_OFF    = 400;

	// One result transaction as seen on tx.
	typedef struct packed {
		byte_t command;
		len_t  payload_length;
		logic  has_byte;
		byte_t data_byte;
		logic  last;
	} beat_t;

	// Where a directed byte comes from, and how its results are judged.
	typedef enum logic [1:0] {SRC_LIT, SRC_CRC_OK, SRC_CRC_BAD} src_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_EMPTY} chk_t;

	typedef struct {
		byte_t value;
		src_t  src;
		chk_t  chk;
		byte_t exp_cmd;
	} dir_row_t;

	// Directed frames under the reset header byte 0xAA.
	dir_row_t dir_rows[26] = '{
		// Empty packet of all zeros: its CRC is zero as well.
		'{8'hAA, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'h00, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'h00, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'h00, SRC_LIT,     CHK_EMPTY, 8'h00},
		// A stray byte while hunting is ignored.
		'{8'h55, SRC_LIT,     CHK_NONE,  8'h00},
		// Length one over the maximum sends the block back to hunting.
		'{8'hAA, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'hFF, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'h21, SRC_LIT,     CHK_NONE,  8'h00},
		// Largest possible length byte.
		'{8'hAA, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'h80, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'hFF, SRC_LIT,     CHK_NONE,  8'h00},
		// A corrupted CRC drops the packet without a result.
		'{8'hAA, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'h7E, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'h01, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'hFF, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'h00, SRC_CRC_BAD, CHK_NONE,  8'h00},
		// Header value inside a frame is plain data.
		'{8'hAA, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'hAA, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'h02, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'hAA, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'h00, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'h00, SRC_CRC_OK,  CHK_MODEL, 8'h00},
		// Empty packet with the largest command.
		'{8'hAA, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'hFF, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'h00, SRC_LIT,     CHK_NONE,  8'h00},
		'{8'h00, SRC_CRC_OK,  CHK_MODEL, 8'h00}
	};

	logic clk;
	logic arst_n;

	cdf_rx_if  rx_ch();
	cdf_tx_if  tx_ch();
	cdf_cfg_if cfg_ch();

	crc8_packet_deframer_core #(.MAX_LEN(MAX_PAY)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch),
		.cfg    (cfg_ch)
	);

	// Parser state mirrored by the testbench.
	byte_t  hdr_now;
	phase_t ph_now;
	byte_t  cmd_now;
	len_t   len_now;
	len_t   wr_idx;
	byte_t  crc_now;
	byte_t  pay_mem[MAX_PAY];

	beat_t beats_due[$];
	beat_t fresh_beats[$];

	int  fails;
	int  rx_count;
	int  hold_reqs;
	bit  burst;

	// CRC-8, polynomial 0x07, MSB first, one byte folded into the accumulator.
	function automatic byte_t crc8_fold(input byte_t acc, input byte_t b);
		byte_t v;
		v = acc ^ b;
		for (int k = 0; k < BYTE_W; k++)
			v = v[BYTE_W-1] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		return v;
	endfunction

	// Advance the mirrored parser by one byte; results land in fresh_beats.
	function automatic void parse_byte(input byte_t b);
		beat_t bt;
		case (ph_now)
			PH_CMD: begin
				cmd_now = b;
				crc_now = crc8_fold(8'h00, b);
				ph_now  = PH_LEN;
			end
			PH_LEN: begin
				if (b > MAX_PAY) begin
					ph_now = PH_HUNT;
				end else begin
					len_now = b[LEN_W-1:0];
					crc_now = crc8_fold(crc_now, b);
					wr_idx  = '0;
					ph_now  = (len_now == 0) ? PH_CRC : PH_DATA;
				end
			end
			PH_DATA: begin
				if (wr_idx < MAX_PAY)
					pay_mem[wr_idx] = b;
				crc_now = crc8_fold(crc_now, b);
				wr_idx  = wr_idx + 1'b1;
				if (wr_idx >= len_now)
					ph_now = PH_CRC;
			end
			PH_CRC: begin
				ph_now = PH_HUNT;
				if (b == crc_now) begin
					if (len_now == 0) begin
						bt = '{cmd_now, '0, 1'b0, '0, 1'b1};
						fresh_beats.push_back(bt);
					end else begin
						for (int k = 0; k < len_now && k < MAX_PAY; k++) begin
							bt = '{cmd_now, len_now, 1'b1, pay_mem[k], (k + 1 == len_now)};
							fresh_beats.push_back(bt);
						end
					end
				end
			end
			default: begin
				ph_now = (b == hdr_now) ? PH_CMD : PH_HUNT;
			end
		endcase
	endfunction

	// Sender idle time before an item: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Payload length of a random frame: small mostly, the maximum now and then.
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 6);
		else if (r < 95)
			return $urandom_range(7, MAX_PAY - 1);
		else
			return MAX_PAY;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		fails++;
	endtask

	// Offer one byte on rx, wait for the transaction and record what it causes.
	task automatic send_byte(input byte_t b, input chk_t chk, input byte_t exp_cmd,
		input bit counted);
		int    gap;
		beat_t bt;
		gap = pick_gap();
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.byte_in <= b;
		do @(posedge clk); while (!rx_ch.ready);
		fresh_beats.delete();
		parse_byte(b);
		case (chk)
			CHK_MODEL: begin
				foreach (fresh_beats[i])
					beats_due.push_back(fresh_beats[i]);
			end
			CHK_EMPTY: begin
				bt = '{exp_cmd, '0, 1'b0, '0, 1'b1};
				beats_due.push_back(bt);
			end
			default: begin
			end
		endcase
		if (counted)
			rx_count++;
	endtask

	// Header, random command, length byte, some payload and optionally a CRC.
	task automatic send_frame(input int len_byte, input int n_data, input byte_t crc_flip,
		input bit with_crc);
		send_byte(hdr_now, CHK_MODEL, '0, 1'b1);
		send_byte(byte_t'($urandom_range(0, 255)), CHK_MODEL, '0, 1'b1);
		send_byte(byte_t'(len_byte), CHK_MODEL, '0, 1'b1);
		repeat (n_data)
			send_byte(byte_t'($urandom_range(0, 255)), CHK_MODEL, '0, 1'b1);
		if (with_crc)
			send_byte(crc_now ^ crc_flip, CHK_MODEL, '0, 1'b1);
	endtask

	task automatic write_header(input byte_t v);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.header_byte <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		hdr_now = v;
		cfg_ch.valid <= 1'b0;
	endtask

	// Wait until every expected result has been taken, with a bound.
	task automatic drain_results();
		int guard;
		guard = 0;
		while (beats_due.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		int go_left;
		int holds_done;
		int r;
		stall_left = 0;
		go_left    = 0;
		holds_done = 0;
		tx_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done < hold_reqs) begin
				holds_done++;
				stall_left = HOLD_OFF;
				go_left    = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				tx_ch.ready <= 1'b0;
			end else if (go_left > 0) begin
				go_left--;
				tx_ch.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50)
					go_left = $urandom_range(1, 20);
				else if (r < 85)
					stall_left = $urandom_range(1, 3);
				else if (r < 95)
					stall_left = $urandom_range(4, 12);
				else
					stall_left = $urandom_range(20, 60);
				tx_ch.ready <= (go_left > 0);
			end
		end
	end

	// Compare every result transaction with the oldest expectation.
	always @(posedge clk) begin : check_beats
		beat_t want;
		if (arst_n && tx_ch.valid && tx_ch.ready) begin
			if (beats_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result: command %02h data %02h last %0b",
					tx_ch.command, tx_ch.data_byte, tx_ch.last));
			end else begin
				want = beats_due.pop_front();
				if (tx_ch.command !== want.command)
					flag_mismatch($sformatf("command got %02h want %02h",
						tx_ch.command, want.command));
				if (tx_ch.payload_length !== want.payload_length)
					flag_mismatch($sformatf("payload_length got %0d want %0d",
						tx_ch.payload_length, want.payload_length));
				if (tx_ch.has_byte !== want.has_byte)
					flag_mismatch($sformatf("has_byte got %0b want %0b",
						tx_ch.has_byte, want.has_byte));
				if (tx_ch.data_byte !== want.data_byte)
					flag_mismatch($sformatf("data_byte got %02h want %02h",
						tx_ch.data_byte, want.data_byte));
				if (tx_ch.last !== want.last)
					flag_mismatch($sformatf("last got %0b want %0b",
						tx_ch.last, want.last));
			end
		end
	end

	// Stimulus: directed frames, then random traffic under several header bytes.
	initial begin
		int    ph_start;
		int    r;
		int    len;
		byte_t b;
		byte_t hdr_plan[N_PHASES];

		arst_n             <= 1'b0;
		rx_ch.valid        <= 1'b0;
		rx_ch.byte_in      <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.header_byte <= HEADER_RESET;
		burst     = 1'b0;
		fails     = 0;
		rx_count  = 0;
		hold_reqs = 0;
		hdr_now   = HEADER_RESET;
		ph_now    = PH_HUNT;
		cmd_now   = '0;
		len_now   = '0;
		wr_idx    = '0;
		crc_now   = '0;

		hdr_plan[0] = HEADER_RESET;
		hdr_plan[1] = 8'h00;
		hdr_plan[2] = 8'hFF;
		hdr_plan[3] = byte_t'($urandom_range(0, 255));
		hdr_plan[4] = 8'h3C;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].src)
				SRC_CRC_OK:  b = crc_now;
				SRC_CRC_BAD: b = ~crc_now;
				default:     b = dir_rows[i].value;
			endcase
			send_byte(b, dir_rows[i].chk, dir_rows[i].exp_cmd, 1'b1);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			// The header byte changes only once the block has gone quiet.
			if (p > 0) begin
				rx_ch.valid <= 1'b0;
				drain_results();
				repeat (SETTLE) @(posedge clk);
				write_header(hdr_plan[p]);
			end
			// In this phase the receiver holds off while frames keep coming.
			if (p == 2)
				hold_reqs++;
			ph_start = rx_count;
			if (p == 1)
				send_frame(MAX_PAY, MAX_PAY, 8'h00, 1'b1);
			while (rx_count - ph_start < PER_PHASE) begin
				burst = (p == 2 && rx_count - ph_start < 48) || ($urandom_range(0, 99) < 25);
				r = $urandom_range(0, 99);
				if (r < 75) begin
					len = pick_len();
					send_frame(len, len, 8'h00, 1'b1);
				end else if (r < 83) begin
					len = pick_len();
					send_frame(len, len, byte_t'($urandom_range(1, 255)), 1'b1);
				end else if (r < 89) begin
					send_frame($urandom_range(MAX_PAY + 1, 255), 0, 8'h00, 1'b0);
				end else if (r < 94) begin
					// Frame cut short: whatever follows is taken as its payload.
					len = $urandom_range(2, 20);
					send_frame(len, $urandom_range(1, len - 1), 8'h00, 1'b0);
				end else begin
					repeat ($urandom_range(1, 4)) begin
						b = byte_t'($urandom_range(0, 255));
						if (b == hdr_now)
							b = b ^ 8'h01;
						send_byte(b, CHK_MODEL, '0, 1'b0);
					end
				end
			end
		end

		rx_ch.valid <= 1'b0;
		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (beats_due.size() != 0)
			flag_mismatch($sformatf("%0d expected results never arrived", beats_due.size()));

		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/cdf_pkg.sv
src/cdf_rx_if.sv
src/cdf_tx_if.sv
src/cdf_cfg_if.sv
src/cdf_crc.sv
src/cdf_store.sv
src/crc8_packet_deframer_core.sv
bench/tb_crc8_packet_deframer_core.sv
